// ===== rtl/i2cts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cts_pkg: shared types and constants of the I2C target byte sequencer
// Phase, command, bus action and register codes, plus the config and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cts_pkg;

  localparam int RX_DEPTH_DEF = 32;
  localparam int TX_BLOCK_DEF = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [6:0] OWN_ADDR_RST = 7'h42;
  localparam logic [5:0] RX_LIMIT_RST = 6'd25;
  localparam logic [7:0] TX_OFFSET_RST = 8'h42;

  typedef enum logic [2:0] {
    PH_WAIT        = 3'd0,
    PH_ADDR        = 3'd1,
    PH_ACK_ADDR_TX = 3'd2,
    PH_SEND        = 3'd3,
    PH_ACK_IN      = 3'd4,
    PH_ACK_GEN     = 3'd5,
    PH_ACK_RX      = 3'd6,
    PH_RECV        = 3'd7
  } phase_t;

  localparam logic [1:0] CMD_START      = 2'd0;
  localparam logic [1:0] CMD_START_STOP = 2'd1;
  localparam logic [1:0] CMD_DONE       = 2'd2;

  localparam logic [2:0] ACT_RELEASE   = 3'd0;
  localparam logic [2:0] ACT_DRIVE_ACK = 3'd1;
  localparam logic [2:0] ACT_SEND      = 3'd2;
  localparam logic [2:0] ACT_SAMPLE    = 3'd3;
  localparam logic [2:0] ACT_RECV      = 3'd4;
  localparam logic [2:0] ACT_RECV_ADDR = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RX_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TX_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RX_LIMIT  = 2'd3;

  typedef struct packed {
    logic [6:0] own_address;
    logic       rx_enable;
    logic       tx_enable;
    logic [5:0] rx_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [2:0] phase;
    logic [7:0] tx_byte;
    logic       rx_stored;
    logic [4:0] rx_index;
    logic       rx_done;
    logic [5:0] rx_done_count;
    logic       tx_done;
    logic [2:0] tx_done_count;
  } res_t;

  function automatic logic [2:0] action_of_phase(input phase_t ph);
    logic [2:0] act;
    unique case (ph)
      PH_WAIT:        act = ACT_RELEASE;
      PH_ADDR:        act = ACT_RECV_ADDR;
      PH_ACK_ADDR_TX: act = ACT_DRIVE_ACK;
      PH_SEND:        act = ACT_SEND;
      PH_ACK_IN:      act = ACT_SAMPLE;
      PH_ACK_GEN:     act = ACT_DRIVE_ACK;
      PH_ACK_RX:      act = ACT_DRIVE_ACK;
      PH_RECV:        act = ACT_RECV;
      default:        act = ACT_RELEASE;
    endcase
    return act;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cts_ifs.sv =====
// ----------------------------------------------------------------------------
// i2cts_ifs: channel interfaces of the I2C target byte sequencer
// Event input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface i2cts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] shift_byte;

  modport source (output valid, command, shift_byte, input ready);
  modport sink   (input valid, command, shift_byte, output ready);
endinterface

interface i2cts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_action;
  logic [2:0] phase;
  logic [7:0] tx_byte;
  logic       rx_stored;
  logic [4:0] rx_index;
  logic       rx_done;
  logic [5:0] rx_done_count;
  logic       tx_done;
  logic [2:0] tx_done_count;

  modport source (output valid, bus_action, phase, tx_byte, rx_stored, rx_index,
                  rx_done, rx_done_count, tx_done, tx_done_count, input ready);
  modport sink   (input valid, bus_action, phase, tx_byte, rx_stored, rx_index,
                  rx_done, rx_done_count, tx_done, tx_done_count, output ready);
endinterface

interface i2cts_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [i2cts_pkg::CFG_IDX_W-1:0]  index;
  logic [i2cts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cts_core.sv =====
// ----------------------------------------------------------------------------
// i2cts_core: transfer phase and counters of the I2C target sequencer
// Decides one bus event per step and updates phase, read and write counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cts_core #(
  parameter int RX_DEPTH = i2cts_pkg::RX_DEPTH_DEF,
  parameter int TX_BLOCK = i2cts_pkg::TX_BLOCK_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [1:0]      command,
  input  wire logic [7:0]      shift_byte,
  input  wire i2cts_pkg::cfg_t cfg,
  output i2cts_pkg::res_t      res
);

  localparam int SentW = $clog2(TX_BLOCK + 1);
  localparam logic [SentW-1:0] BlockLen = SentW'(TX_BLOCK);
  localparam logic [8:0] RxCap = 9'(RX_DEPTH);

  i2cts_pkg::phase_t phase_r, phase_nxt;
  logic [SentW-1:0]  tx_sent_r, tx_sent_nxt;
  logic [SentW-1:0]  tx_loaded_r, tx_loaded_nxt;
  logic [7:0]        tx_offset_r, tx_offset_nxt;
  logic [5:0]        rx_received_r, rx_received_nxt;

  logic             is_start;
  logic             addr_hit;
  logic             byte_zero;
  logic [7:0]       tx_sum;
  logic             tx_reload;
  logic [SentW-1:0] sent_dec;
  logic [8:0]       rx_lim;
  logic             rx_room;

  assign is_start  = command != i2cts_pkg::CMD_DONE;
  assign addr_hit  = shift_byte[7:1] == cfg.own_address;
  assign byte_zero = shift_byte == 8'd0;
  assign tx_sum    = tx_offset_r + 8'(tx_sent_r);
  assign tx_reload = tx_sent_r >= tx_loaded_r;
  assign sent_dec  = (tx_sent_r != '0) ? tx_sent_r - SentW'(1) : '0;
  assign rx_lim    = (9'(cfg.rx_limit) < RxCap) ? 9'(cfg.rx_limit) : RxCap;
  assign rx_room   = 9'(rx_received_r) < rx_lim;

  always_comb begin
    phase_nxt = i2cts_pkg::PH_WAIT;
    if (is_start) begin
      phase_nxt = (command == i2cts_pkg::CMD_START) ? i2cts_pkg::PH_ADDR
                                                    : i2cts_pkg::PH_WAIT;
    end else begin
      unique case (phase_r)
        i2cts_pkg::PH_ADDR: begin
          if (byte_zero) begin
            phase_nxt = i2cts_pkg::PH_ACK_GEN;
          end else if (addr_hit && shift_byte[0]) begin
            phase_nxt = cfg.tx_enable ? i2cts_pkg::PH_ACK_ADDR_TX : i2cts_pkg::PH_WAIT;
          end else if (addr_hit) begin
            phase_nxt = cfg.rx_enable ? i2cts_pkg::PH_ACK_RX : i2cts_pkg::PH_WAIT;
          end
        end
        i2cts_pkg::PH_ACK_IN: begin
          if (byte_zero && cfg.tx_enable) phase_nxt = i2cts_pkg::PH_SEND;
        end
        i2cts_pkg::PH_ACK_ADDR_TX: begin
          if (cfg.tx_enable) phase_nxt = i2cts_pkg::PH_SEND;
        end
        i2cts_pkg::PH_SEND:   phase_nxt = i2cts_pkg::PH_ACK_IN;
        i2cts_pkg::PH_ACK_RX: phase_nxt = i2cts_pkg::PH_RECV;
        i2cts_pkg::PH_RECV: begin
          if (cfg.rx_enable && rx_room) phase_nxt = i2cts_pkg::PH_ACK_RX;
        end
        default: phase_nxt = i2cts_pkg::PH_WAIT;
      endcase
    end
  end

  always_comb begin
    res             = '0;
    tx_sent_nxt     = tx_sent_r;
    tx_loaded_nxt   = tx_loaded_r;
    tx_offset_nxt   = tx_offset_r;
    rx_received_nxt = rx_received_r;
    if (is_start) begin
      if (rx_received_r != '0) begin
        res.rx_done       = 1'b1;
        res.rx_done_count = rx_received_r;
        rx_received_nxt   = '0;
      end
      if (tx_sent_r != '0) begin
        res.tx_done       = 1'b1;
        res.tx_done_count = 3'(tx_sent_r);
        tx_loaded_nxt     = '0;
        tx_sent_nxt       = '0;
      end
    end else begin
      case (phase_r) inside
        i2cts_pkg::PH_ADDR: begin
          if (!byte_zero && addr_hit && shift_byte[0] && cfg.tx_enable &&
              tx_loaded_r == '0) begin
            tx_offset_nxt = tx_sum;
            tx_loaded_nxt = BlockLen;
            tx_sent_nxt   = '0;
          end
        end
        i2cts_pkg::PH_ACK_IN, i2cts_pkg::PH_ACK_ADDR_TX: begin
          if (phase_r == i2cts_pkg::PH_ACK_IN && !byte_zero) begin
            tx_sent_nxt = '0;
            if (sent_dec != '0) begin
              res.tx_done       = 1'b1;
              res.tx_done_count = 3'(sent_dec);
              tx_loaded_nxt     = '0;
            end
          end else if (cfg.tx_enable) begin
            res.tx_byte = tx_sum;
            if (tx_reload) begin
              tx_offset_nxt = tx_sum;
              tx_loaded_nxt = BlockLen;
              tx_sent_nxt   = SentW'(1);
            end else begin
              tx_sent_nxt = tx_sent_r + SentW'(1);
            end
          end
        end
        i2cts_pkg::PH_RECV: begin
          if (cfg.rx_enable && rx_room) begin
            res.rx_stored   = 1'b1;
            res.rx_index    = rx_received_r[4:0];
            rx_received_nxt = rx_received_r + 6'd1;
          end else if (cfg.rx_enable && rx_received_r != '0) begin
            res.rx_done       = 1'b1;
            res.rx_done_count = rx_received_r;
            rx_received_nxt   = '0;
          end
        end
        default: ;
      endcase
    end
    res.phase      = phase_nxt;
    res.bus_action = i2cts_pkg::action_of_phase(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= i2cts_pkg::PH_WAIT;
      tx_sent_r     <= '0;
      tx_loaded_r   <= '0;
      tx_offset_r   <= i2cts_pkg::TX_OFFSET_RST;
      rx_received_r <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      tx_sent_r     <= tx_sent_nxt;
      tx_loaded_r   <= tx_loaded_nxt;
      tx_offset_r   <= tx_offset_nxt;
      rx_received_r <= rx_received_nxt;
    end
  end

  a_sent_within_block: assert property (@(posedge clk) disable iff (!rst_n)
    tx_sent_r <= tx_loaded_r)
    else $error("read count exceeds loaded block");

  a_store_goes_to_ack: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.rx_stored |=> phase_r == i2cts_pkg::PH_ACK_RX)
    else $error("stored write byte not followed by ack phase");

  a_send_has_sent: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_nxt == i2cts_pkg::PH_SEND |=> tx_sent_r != '0)
    else $error("send phase without a counted byte");

endmodule

`default_nettype wire

// ===== rtl/i2c_target_byte_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_target_byte_sequencer: byte-level I2C target transfer sequencer
// Registers one bus event, decides it combinationally and holds the result word.
//
//   channel  dir  role
//   in_bus   in   bus event word: command, shift_byte
//   out_bus  out  result word: bus action, phase, tx byte, stores and counts
//   cfg_bus  in   register write: index, data; always ready
//
// One event word per cycle unless the result side stalls; an accepted event passes
// the event register, then the result register. The event register feeds the phase
// logic, the result register the output. A stalled result holds; one further event
// waits in the event register. Synchronous active-low reset returns phase to waiting
// and registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module i2c_target_byte_sequencer #(
  parameter int RX_DEPTH = i2cts_pkg::RX_DEPTH_DEF,
  parameter int TX_BLOCK = i2cts_pkg::TX_BLOCK_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  i2cts_in_if.sink    in_bus,
  i2cts_out_if.source out_bus,
  i2cts_cfg_if.sink   cfg_bus
);

  logic            in_v_r;
  logic [1:0]      command_r;
  logic [7:0]      shift_byte_r;
  logic            out_v_r, out_v_nxt;
  i2cts_pkg::res_t res_r;
  i2cts_pkg::res_t res;
  i2cts_pkg::cfg_t cfg_r;
  logic            adv;
  logic            in_take;

  assign adv     = in_v_r && (!out_v_r || out_bus.ready);
  assign in_take = in_bus.valid && in_bus.ready;
  assign in_bus.ready  = !in_v_r || adv;
  assign cfg_bus.ready = 1'b1;
  assign out_v_nxt     = adv || (out_v_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      command_r    <= in_bus.command;
      shift_byte_r <= in_bus.shift_byte;
    end
  end

  i2cts_core #(
    .RX_DEPTH (RX_DEPTH),
    .TX_BLOCK (TX_BLOCK)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .command    (command_r),
    .shift_byte (shift_byte_r),
    .cfg        (cfg_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address <= i2cts_pkg::OWN_ADDR_RST;
      cfg_r.rx_enable   <= 1'b1;
      cfg_r.tx_enable   <= 1'b1;
      cfg_r.rx_limit    <= i2cts_pkg::RX_LIMIT_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        i2cts_pkg::REG_OWN_ADDR:  cfg_r.own_address <= cfg_bus.data[6:0];
        i2cts_pkg::REG_RX_ENABLE: cfg_r.rx_enable   <= cfg_bus.data[0];
        i2cts_pkg::REG_TX_ENABLE: cfg_r.tx_enable   <= cfg_bus.data[0];
        i2cts_pkg::REG_RX_LIMIT:  cfg_r.rx_limit    <= cfg_bus.data[5:0];
        default: ;
      endcase
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.bus_action    = res_r.bus_action;
  assign out_bus.phase         = res_r.phase;
  assign out_bus.tx_byte       = res_r.tx_byte;
  assign out_bus.rx_stored     = res_r.rx_stored;
  assign out_bus.rx_index      = res_r.rx_index;
  assign out_bus.rx_done       = res_r.rx_done;
  assign out_bus.rx_done_count = res_r.rx_done_count;
  assign out_bus.tx_done       = res_r.tx_done;
  assign out_bus.tx_done_count = res_r.tx_done_count;

  a_event_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(command_r) && $stable(shift_byte_r))
    else $error("pending event word lost");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("decided event produced no result word");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_bus.ready |=> out_v_r && $stable(res_r))
    else $error("stalled result word changed");

  a_send_byte_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.bus_action != i2cts_pkg::ACT_SEND |-> res_r.tx_byte == 8'd0)
    else $error("tx byte set outside send action");

endmodule

`default_nettype wire

// ===== dv/i2c_target_byte_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_target_byte_sequencer_tb: self-checking bench for the I2C byte sequencer
// Drives bus event words and register writes through the valid/ready channels.
// A scoreboard tracks phase, read block and write count and predicts each
// result word. Directed events come first, then well-formed read, write and
// general call transfers with random content, mixed with noise and cut
// transfers, under eight register settings. Both sides stall at random, and
// the result side holds off once for a long stretch so that the block fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_target_byte_sequencer_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_PCT = 38;
  localparam int EVENT_TARGET = 700;
  localparam int NUM_SETTINGS = 8;
  localparam int HOLD_CYCLES = 300;

  class byte_seq_scoreboard;
    logic [6:0]        own_addr;
    logic              rx_en;
    logic              tx_en;
    logic [5:0]        rx_lim;
    i2cts_pkg::phase_t ph;
    int unsigned       tx_sent;
    int unsigned       tx_loaded;
    int unsigned       rx_count;
    logic [7:0]        tx_offset;
    i2cts_pkg::res_t   pending_results[$];
    int unsigned       errors;

    function new();
      own_addr  = i2cts_pkg::OWN_ADDR_RST;
      rx_en     = 1'b1;
      tx_en     = 1'b1;
      rx_lim    = i2cts_pkg::RX_LIMIT_RST;
      ph        = i2cts_pkg::PH_WAIT;
      tx_sent   = 0;
      tx_loaded = 0;
      rx_count  = 0;
      tx_offset = i2cts_pkg::TX_OFFSET_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [i2cts_pkg::CFG_IDX_W-1:0] idx,
                            logic [i2cts_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        i2cts_pkg::REG_OWN_ADDR:  own_addr = data[6:0];
        i2cts_pkg::REG_RX_ENABLE: rx_en    = data[0];
        i2cts_pkg::REG_TX_ENABLE: tx_en    = data[0];
        i2cts_pkg::REG_RX_LIMIT:  rx_lim   = data[5:0];
        default: ;
      endcase
    endfunction

    function logic [2:0] action_for(i2cts_pkg::phase_t p);
      case (p) inside
        i2cts_pkg::PH_ADDR: return i2cts_pkg::ACT_RECV_ADDR;
        i2cts_pkg::PH_ACK_ADDR_TX, i2cts_pkg::PH_ACK_GEN, i2cts_pkg::PH_ACK_RX:
          return i2cts_pkg::ACT_DRIVE_ACK;
        i2cts_pkg::PH_SEND:   return i2cts_pkg::ACT_SEND;
        i2cts_pkg::PH_ACK_IN: return i2cts_pkg::ACT_SAMPLE;
        i2cts_pkg::PH_RECV:   return i2cts_pkg::ACT_RECV;
        default:              return i2cts_pkg::ACT_RELEASE;
      endcase
    endfunction

    function void reload_block();
      tx_offset = tx_offset + tx_sent[7:0];
      tx_loaded = i2cts_pkg::TX_BLOCK_DEF;
      tx_sent   = 0;
    endfunction

    function void report_read(inout i2cts_pkg::res_t r);
      r.tx_done       = 1'b1;
      r.tx_done_count = tx_sent[2:0];
      tx_loaded       = 0;
      tx_sent         = 0;
    endfunction

    function void report_write(inout i2cts_pkg::res_t r);
      r.rx_done       = 1'b1;
      r.rx_done_count = rx_count[5:0];
      rx_count        = 0;
    endfunction

    function bit send_next(inout i2cts_pkg::res_t r);
      if (!tx_en) return 1'b0;
      if (tx_sent >= tx_loaded) reload_block();
      if (tx_sent < tx_loaded) begin
        r.tx_byte = tx_offset + tx_sent[7:0];
        tx_sent++;
        ph = i2cts_pkg::PH_SEND;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_event(logic [1:0] cmd, logic [7:0] sbyte);
      i2cts_pkg::res_t r;
      int unsigned     lim;
      r = '0;
      lim = (int'(rx_lim) < i2cts_pkg::RX_DEPTH_DEF) ? int'(rx_lim)
                                                     : i2cts_pkg::RX_DEPTH_DEF;
      if (cmd != i2cts_pkg::CMD_DONE) begin
        ph = (cmd == i2cts_pkg::CMD_START) ? i2cts_pkg::PH_ADDR : i2cts_pkg::PH_WAIT;
        if (rx_count != 0) report_write(r);
        if (tx_sent != 0) report_read(r);
      end else begin
        case (ph)
          i2cts_pkg::PH_ADDR: begin
            if (sbyte == 8'h00) begin
              ph = i2cts_pkg::PH_ACK_GEN;
            end else if (sbyte[7:1] == own_addr) begin
              if (sbyte[0]) begin
                if (tx_en) begin
                  if (tx_loaded == 0) reload_block();
                  ph = i2cts_pkg::PH_ACK_ADDR_TX;
                end else begin
                  ph = i2cts_pkg::PH_WAIT;
                end
              end else begin
                ph = rx_en ? i2cts_pkg::PH_ACK_RX : i2cts_pkg::PH_WAIT;
              end
            end else begin
              ph = i2cts_pkg::PH_WAIT;
            end
          end
          i2cts_pkg::PH_ACK_IN: begin
            if (sbyte != 8'h00) begin
              if (tx_sent != 0) tx_sent--;
              if (tx_sent != 0) report_read(r);
              ph = i2cts_pkg::PH_WAIT;
            end else if (!send_next(r)) begin
              ph = i2cts_pkg::PH_WAIT;
            end
          end
          i2cts_pkg::PH_ACK_ADDR_TX: begin
            if (!send_next(r)) ph = i2cts_pkg::PH_WAIT;
          end
          i2cts_pkg::PH_SEND:   ph = i2cts_pkg::PH_ACK_IN;
          i2cts_pkg::PH_ACK_RX: ph = i2cts_pkg::PH_RECV;
          i2cts_pkg::PH_RECV: begin
            ph = i2cts_pkg::PH_WAIT;
            if (rx_en) begin
              if (rx_count < lim) begin
                r.rx_stored = 1'b1;
                r.rx_index  = rx_count[4:0];
                rx_count++;
                ph = i2cts_pkg::PH_ACK_RX;
              end else if (rx_count != 0) begin
                report_write(r);
              end
            end
          end
          default: ph = i2cts_pkg::PH_WAIT;
        endcase
      end
      r.phase      = ph;
      r.bus_action = action_for(ph);
      if (r.bus_action != i2cts_pkg::ACT_SEND) r.tx_byte = '0;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(i2cts_pkg::res_t got);
      i2cts_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $error("result word with no expectation: phase %0d", got.phase);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("bus_action", 8'(want.bus_action), 8'(got.bus_action));
      compare_field("phase", 8'(want.phase), 8'(got.phase));
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("rx_stored", 8'(want.rx_stored), 8'(got.rx_stored));
      compare_field("rx_index", 8'(want.rx_index), 8'(got.rx_index));
      compare_field("rx_done", 8'(want.rx_done), 8'(got.rx_done));
      compare_field("rx_done_count", 8'(want.rx_done_count), 8'(got.rx_done_count));
      compare_field("tx_done", 8'(want.tx_done), 8'(got.tx_done));
      compare_field("tx_done_count", 8'(want.tx_done_count), 8'(got.tx_done_count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  i2cts_in_if  in_bus();
  i2cts_out_if out_bus();
  i2cts_cfg_if cfg_bus();

  byte_seq_scoreboard sb = new();

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned events_sent = 0;
  logic [6:0]  target_addr = i2cts_pkg::OWN_ADDR_RST;

  i2c_target_byte_sequencer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic offer_event(logic [1:0] cmd, logic [7:0] sbyte);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.command    <= cmd;
    in_bus.shift_byte <= sbyte;
    do @(posedge clk); while (!in_bus.ready);
    sb.take_event(cmd, sbyte);
    events_sent++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [i2cts_pkg::CFG_IDX_W-1:0] idx,
                           logic [i2cts_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic program_setting(logic [6:0] own, logic rx, logic tx, logic [5:0] lim);
    logic [7:0] noise;
    noise = 8'($urandom);
    drain();
    cfg_write(i2cts_pkg::REG_OWN_ADDR, {noise[7], own});
    cfg_write(i2cts_pkg::REG_RX_ENABLE, {noise[6:0], rx});
    cfg_write(i2cts_pkg::REG_TX_ENABLE, {noise[7:1], tx});
    cfg_write(i2cts_pkg::REG_RX_LIMIT, {noise[1:0], lim});
    cfg_bus.valid <= 1'b0;
    target_addr = own;
  endtask

  task automatic write_transfer(logic [6:0] addr, int unsigned nbytes);
    offer_event(i2cts_pkg::CMD_START, 8'($urandom));
    offer_event(i2cts_pkg::CMD_DONE, {addr, 1'b0});
    repeat (nbytes) begin
      offer_event(i2cts_pkg::CMD_DONE, 8'($urandom));
      offer_event(i2cts_pkg::CMD_DONE, 8'($urandom));
    end
  endtask

  task automatic read_transfer(logic [6:0] addr, int unsigned nbytes, bit nack_last);
    logic [7:0] ack;
    offer_event(i2cts_pkg::CMD_START, 8'($urandom));
    offer_event(i2cts_pkg::CMD_DONE, {addr, 1'b1});
    offer_event(i2cts_pkg::CMD_DONE, 8'($urandom));
    for (int unsigned i = 0; i < nbytes; i++) begin
      offer_event(i2cts_pkg::CMD_DONE, 8'($urandom));
      if ((i == nbytes - 1 && nack_last) || $urandom_range(19) == 0)
        ack = 8'($urandom_range(1, 255));
      else
        ack = 8'h00;
      offer_event(i2cts_pkg::CMD_DONE, ack);
    end
  endtask

  task automatic close_transfer();
    int unsigned pick;
    pick = $urandom_range(9);
    // leave the transfer open on the remaining picks
    if (pick < 4) offer_event(i2cts_pkg::CMD_START_STOP, 8'($urandom));
    else if (pick < 6) offer_event(i2cts_pkg::CMD_START, 8'($urandom));
    else if (pick < 7) offer_event(CMD_UNUSED, 8'($urandom));
  endtask

  task automatic random_transfer();
    int unsigned kind;
    logic [6:0]  addr;
    kind = $urandom_range(99);
    addr = ($urandom_range(9) < 8) ? target_addr : 7'($urandom);
    if (kind < 40) begin
      write_transfer(addr, ($urandom_range(7) == 0) ? $urandom_range(30, 36)
                                                    : $urandom_range(0, 6));
    end else if (kind < 78) begin
      read_transfer(addr, $urandom_range(0, 9), $urandom_range(3) != 0);
    end else if (kind < 85) begin
      offer_event(i2cts_pkg::CMD_START, 8'($urandom));
      offer_event(i2cts_pkg::CMD_DONE, 8'h00);
      offer_event(i2cts_pkg::CMD_DONE, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) offer_event(2'($urandom), 8'($urandom));
    end
    close_transfer();
  endtask

  always @(posedge clk) begin : result_monitor
    i2cts_pkg::res_t seen;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen.bus_action    = out_bus.bus_action;
      seen.phase         = out_bus.phase;
      seen.tx_byte       = out_bus.tx_byte;
      seen.rx_stored     = out_bus.rx_stored;
      seen.rx_index      = out_bus.rx_index;
      seen.rx_done       = out_bus.rx_done;
      seen.rx_done_count = out_bus.rx_done_count;
      seen.tx_done       = out_bus.tx_done;
      seen.tx_done_count = out_bus.tx_done_count;
      sb.check_result(seen);
    end
  end

  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int unsigned base;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.command    <= i2cts_pkg::CMD_START;
    in_bus.shift_byte <= 8'h00;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= i2cts_pkg::REG_OWN_ADDR;
    cfg_bus.data      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_event(i2cts_pkg::CMD_DONE, 8'hFF);
    offer_event(CMD_UNUSED, 8'h00);
    offer_event(i2cts_pkg::CMD_START, 8'hFF);
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    offer_event(i2cts_pkg::CMD_START, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, {i2cts_pkg::OWN_ADDR_RST, 1'b0});
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, 8'hFF);
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    offer_event(i2cts_pkg::CMD_START_STOP, 8'h00);
    offer_event(i2cts_pkg::CMD_START, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, {i2cts_pkg::OWN_ADDR_RST, 1'b1});
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, 8'hFF);
    offer_event(i2cts_pkg::CMD_START, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, 8'hFE);
    offer_event(i2cts_pkg::CMD_START_STOP, 8'hFF);

    // drop the write enable in the middle of a write
    offer_event(i2cts_pkg::CMD_START, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, {i2cts_pkg::OWN_ADDR_RST, 1'b0});
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    offer_event(i2cts_pkg::CMD_DONE, 8'h5A);
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    drain();
    cfg_write(i2cts_pkg::REG_RX_ENABLE, 8'h00);
    cfg_bus.valid <= 1'b0;
    offer_event(i2cts_pkg::CMD_DONE, 8'hA5);
    offer_event(i2cts_pkg::CMD_START, 8'h00);
    // drop the read enable after the address word
    offer_event(i2cts_pkg::CMD_DONE, {i2cts_pkg::OWN_ADDR_RST, 1'b1});
    drain();
    cfg_write(i2cts_pkg::REG_TX_ENABLE, 8'h00);
    cfg_bus.valid <= 1'b0;
    offer_event(i2cts_pkg::CMD_DONE, 8'h00);
    offer_event(i2cts_pkg::CMD_START_STOP, 8'h00);

    base = events_sent;
    for (int k = 0; k < NUM_SETTINGS; k++) begin
      case (k)
        0: program_setting(i2cts_pkg::OWN_ADDR_RST, 1'b1, 1'b1, i2cts_pkg::RX_LIMIT_RST);
        1: program_setting(7'h01, 1'b1, 1'b1, 6'd1);
        2: program_setting(7'h7F, 1'b1, 1'b1, 6'd32);
        3: program_setting(7'h00, 1'b1, 1'b1, 6'd63);
        4: program_setting(7'h2A, 1'b0, 1'b1, 6'd8);
        5: program_setting(7'h55, 1'b1, 1'b0, 6'd0);
        default: program_setting(7'($urandom_range(1, 127)), $urandom_range(3) != 0,
                                 $urandom_range(3) != 0, 6'($urandom_range(1, 32)));
      endcase
      idle_on = (k != 3);
      if (k == 2) hold_req = 1'b1;
      while (events_sent < base + (k + 1) * EVENT_TARGET / NUM_SETTINGS)
        random_transfer();
    end
    idle_on = 1'b1;

    drain();
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("i2c_target_byte_sequencer_tb OK");
    end else begin
      $display("i2c_target_byte_sequencer_tb NOT OK");
    end
    $finish;
  end

  initial begin : run_limit
    #400000;
    $display("i2c_target_byte_sequencer_tb NOT OK");
    $finish;
  end

endmodule
